@@ hdl/bst_pkg.sv @@
// shared constants, types and helpers for the bucket slot table
`timescale 1ns / 1ps

package bst_pkg;

	// bucket geometry
	localparam int SLOTS      = 8;
	localparam int VALUE_BITS = 32;
	localparam int KEY_BITS   = 32;
	localparam int FOUND_BITS = 32;
	localparam int OCC_BITS   = 4;
	localparam int IDX_BITS   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int COUNT_BITS = $clog2(SLOTS + 1);

	typedef logic [IDX_BITS-1:0]   idx_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [KEY_BITS-1:0]   key_t;
	typedef logic [VALUE_BITS-1:0] value_t;

	localparam idx_t LAST_IDX = idx_t'(SLOTS - 1);

	// operation codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_UPDATE = 2'd3;

	// slot write command from the sequencer to the store
	typedef struct packed {
		logic   data_we;
		logic   set_valid;
		logic   clr_valid;
		idx_t   addr;
		key_t   key;
		value_t value;
	} slot_wr_t;

	// occupancy as reported, saturated to the output width
	function automatic logic [OCC_BITS-1:0] occ_sat(input count_t count);
		logic [OCC_BITS-1:0] res;
		if (32'(count) > 32'd15) begin
			res = 4'd15;
		end else begin
			res = OCC_BITS'(count);
		end
		return res;
	endfunction

endpackage

@@ hdl/bst_slot_store.sv @@
// slot store: key/value memory, valid flags and occupancy count
`timescale 1ns / 1ps

module bst_slot_store import bst_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  idx_t     rd_addr,
	input  slot_wr_t wr,
	output idx_t     rd_idx,
	output key_t     rd_key,
	output value_t   rd_value,
	output logic     rd_valid,
	output count_t   count
);

	key_t         key_mem [SLOTS];
	value_t       val_mem [SLOTS];
	logic [SLOTS-1:0] valid_q;
	count_t       count_q;
	idx_t         rd_idx_q;
	key_t         rd_key_q;
	value_t       rd_value_q;

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (wr.data_we) begin
			key_mem[wr.addr] <= wr.key;
			val_mem[wr.addr] <= wr.value;
		end
		rd_key_q   <= key_mem[rd_addr];
		rd_value_q <= val_mem[rd_addr];
		rd_idx_q   <= rd_addr;
	end

	// valid flags and occupancy count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else begin
			if (wr.set_valid) begin
				valid_q[wr.addr] <= 1'b1;
				count_q <= count_q + COUNT_BITS'(1);
			end else if (wr.clr_valid) begin
				valid_q[wr.addr] <= 1'b0;
				count_q <= count_q - COUNT_BITS'(1);
			end
		end
	end

	assign rd_idx   = rd_idx_q;
	assign rd_key   = rd_key_q;
	assign rd_value = rd_value_q;
	assign rd_valid = valid_q[rd_idx_q];
	assign count    = count_q;

	// count tracks the valid flags
	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) == $countones(valid_q))
		else $error("occupancy count differs from valid flags");

	// insert only lands on a free slot
	a_set_free: assert property (@(posedge clk) disable iff (!arst_n)
		wr.set_valid |-> !valid_q[wr.addr])
		else $error("insert into an occupied slot");

	// remove only frees an occupied slot
	a_clr_used: assert property (@(posedge clk) disable iff (!arst_n)
		wr.clr_valid |-> valid_q[wr.addr])
		else $error("remove of a free slot");

endmodule

@@ hdl/bucket_slot_table.sv @@
// top level of the bucket slot table: scan sequencer and result register
`timescale 1ns / 1ps
//
// One bucket of SLOTS records (valid, key, value) for a hash table.
// Input channel (in_valid/in_ready) carries kind, key and entry_value:
// insert, lookup, remove or update. Output channel (out_valid/out_ready)
// carries success, found_value, occupancy, is_full and is_empty, one
// result per input transfer, in order.
// An operation scans the slot memory from index 0 upward, one slot per
// cycle through the single key compare; the memory read is registered, and
// the scan stops at the first hit or at the last slot. in_ready is high
// only while no operation is in flight, so one item is worked at a time.
// The result sits in an output register: a new item is taken while the
// previous result waits, and if the receiver still stalls when the next
// result is ready, the block holds it and stays busy until out_ready.
// Reset clears all valid flags and the count at once; no clearing pass.
//

module bucket_slot_table import bst_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            kind,
	input  logic signed [31:0]    key,
	input  logic [31:0]           entry_value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  success,
	output logic [FOUND_BITS-1:0] found_value,
	output logic [OCC_BITS-1:0]   occupancy,
	output logic                  is_full,
	output logic                  is_empty
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]            state_q;
	logic [1:0]            kind_q;
	key_t                  key_q;
	value_t                value_q;
	idx_t                  idx_q;
	logic                  cmp_vld_q;
	logic                  ok_q;
	logic [FOUND_BITS-1:0] fv_q;
	logic                  out_valid_q;
	logic                  success_q;
	logic [FOUND_BITS-1:0] found_q;
	logic [OCC_BITS-1:0]   occ_q;
	logic                  full_q;
	logic                  empty_q;

	slot_wr_t wr;
	idx_t     rd_idx;
	key_t     rd_key;
	value_t   rd_value;
	logic     rd_valid;
	count_t   count;
	logic     match;
	logic     hit;
	logic     scan_end;
	logic     out_free;

	bst_slot_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (idx_q),
		.wr       (wr),
		.rd_idx   (rd_idx),
		.rd_key   (rd_key),
		.rd_value (rd_value),
		.rd_valid (rd_valid),
		.count    (count)
	);

	// shared compare: free slot for insert, valid key match otherwise
	always_comb begin
		if (kind_q == OP_INSERT) begin
			match = !rd_valid;
		end else begin
			match = rd_valid && (rd_key == key_q);
		end
		hit      = (state_q == ST_SCAN) && cmp_vld_q && match;
		scan_end = (state_q == ST_SCAN) && cmp_vld_q && (match || rd_idx == LAST_IDX);
	end

	// slot write on the hit
	always_comb begin
		wr.data_we   = hit && (kind_q == OP_INSERT || kind_q == OP_UPDATE);
		wr.set_valid = hit && (kind_q == OP_INSERT);
		wr.clr_valid = hit && (kind_q == OP_REMOVE);
		wr.addr      = rd_idx;
		wr.key       = key_q;
		wr.value     = value_q;
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			cmp_vld_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						idx_q     <= '0;
						cmp_vld_q <= 1'b0;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					cmp_vld_q <= 1'b1;
					if (idx_q != LAST_IDX) begin
						idx_q <= idx_q + IDX_BITS'(1);
					end
					if (scan_end) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// operation operands and scan outcome
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_q  <= kind;
			key_q   <= key_t'(key);
			value_q <= value_t'(entry_value);
		end
		if (scan_end) begin
			ok_q <= hit;
			if (hit && kind_q == OP_LOOKUP) begin
				fv_q <= FOUND_BITS'(rd_value);
			end else begin
				fv_q <= '0;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			success_q <= ok_q;
			found_q   <= fv_q;
			occ_q     <= occ_sat(count);
			full_q    <= (count == COUNT_BITS'(SLOTS));
			empty_q   <= (count == '0);
		end
	end

	assign out_valid   = out_valid_q;
	assign success     = success_q;
	assign found_value = found_q;
	assign occupancy   = occ_q;
	assign is_full     = full_q;
	assign is_empty    = empty_q;

	// a finished scan always moves to the result state
	a_scan_done: assert property (@(posedge clk) disable iff (!arst_n)
		scan_end |=> (state_q == ST_DONE))
		else $error("scan ended without result");

	// a result leaving the done state lands in the output register
	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> out_valid_q)
		else $error("result lost on load");

	// a stalled result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q &&
		$stable({success_q, found_q, occ_q, full_q, empty_q})))
		else $error("result changed while stalled");

endmodule

@@ verif/bucket_slot_table_test.sv @@
// self-checking testbench for the bucket slot table
`timescale 1ns / 1ps

module bucket_slot_table_test;
	import bst_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LONG_HOLD      = 300;
	localparam int TAIL_CYCLES    = 16;
	localparam int POOL_SIZE      = 10;

	// one operation on the bucket as offered to the input channel
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] key;
		logic [31:0] data;
	} bucket_op_t;

	// one result as seen on the output channel
	typedef struct packed {
		logic                  success;
		logic [FOUND_BITS-1:0] found;
		logic [OCC_BITS-1:0]   occ;
		logic                  full;
		logic                  empty;
	} bucket_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [1:0]            kind = OP_INSERT;
	logic signed [31:0]    key = '0;
	logic [31:0]           entry_value = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  success;
	logic [FOUND_BITS-1:0] found_value;
	logic [OCC_BITS-1:0]   occupancy;
	logic                  is_full;
	logic                  is_empty;

	// stimulus and expectation stores
	bucket_op_t     pending_ops[$];
	bucket_result_t expected_results[$];

	// shadow copy of the bucket contents
	logic   shadow_valid[SLOTS];
	key_t   shadow_key[SLOTS];
	value_t shadow_value[SLOTS];

	key_t key_pool[POOL_SIZE];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	logic hold_arm = 1'b0;
	logic hold_taken;
	int hold_left;

	int err_count = 0;
	int results_checked = 0;
	int ops_by_kind[4] = '{0, 0, 0, 0};
	int success_count = 0;
	int full_seen = 0;
	int empty_seen = 0;
	int stall_cycles;

	bucket_slot_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.key(key),
		.entry_value(entry_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.success(success),
		.found_value(found_value),
		.occupancy(occupancy),
		.is_full(is_full),
		.is_empty(is_empty)
	);

	always #1 clk = ~clk;

	// apply one operation to the shadow bucket and return its result
	function automatic bucket_result_t bucket_apply(bucket_op_t op);
		bucket_result_t res;
		int hit;
		int cnt;
		res = '0;
		hit = -1;
		cnt = 0;
		if (op.kind == OP_INSERT) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (!shadow_valid[i] && hit < 0) begin
					hit = i;
				end
			end
			if (hit >= 0) begin
				shadow_valid[hit] = 1'b1;
				shadow_key[hit]   = key_t'(op.key);
				shadow_value[hit] = value_t'(op.data);
				res.success       = 1'b1;
			end
		end else begin
			// lowest valid slot holding the key
			for (int i = 0; i < SLOTS; i++) begin
				if (shadow_valid[i] && shadow_key[i] == key_t'(op.key) && hit < 0) begin
					hit = i;
				end
			end
			if (hit >= 0) begin
				res.success = 1'b1;
				case (op.kind)
					OP_LOOKUP: res.found = FOUND_BITS'(shadow_value[hit]);
					OP_REMOVE: shadow_valid[hit] = 1'b0;
					default: shadow_value[hit] = value_t'(op.data);
				endcase
			end
		end
		for (int i = 0; i < SLOTS; i++) begin
			if (shadow_valid[i]) begin
				cnt++;
			end
		end
		res.occ   = (cnt > 15) ? OCC_BITS'(15) : OCC_BITS'(cnt);
		res.full  = (cnt == SLOTS);
		res.empty = (cnt == 0);
		return res;
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch at result %0d: %s", results_checked, msg);
		err_count++;
	endtask

	task automatic push_op(logic [1:0] k, logic [31:0] kv, logic [31:0] dv);
		bucket_op_t op;
		op.kind = k;
		op.key  = kv;
		op.data = dv;
		pending_ops.push_back(op);
	endtask

	// random traffic that alternates between growing and shrinking the bucket
	task automatic queue_random_ops(int count);
		bucket_op_t op;
		logic grow;
		int pick;
		grow = 1'b1;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(19) == 0) begin
				grow = ~grow;
			end
			pick = $urandom_range(99);
			if (grow) begin
				op.kind = (pick < 50) ? OP_INSERT : (pick < 70) ? OP_LOOKUP :
					(pick < 85) ? OP_UPDATE : OP_REMOVE;
			end else begin
				op.kind = (pick < 15) ? OP_INSERT : (pick < 35) ? OP_LOOKUP :
					(pick < 50) ? OP_UPDATE : OP_REMOVE;
			end
			// mostly keys from the pool so that matches happen, some noise keys
			if ($urandom_range(99) < 85) begin
				op.key = key_pool[$urandom_range(POOL_SIZE - 1)];
			end else begin
				op.key = $urandom;
			end
			pick = $urandom_range(9);
			op.data = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hffff_ffff : $urandom;
			pending_ops.push_back(op);
		end
	endtask

	// sender pauses until every expected result has arrived
	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0);
	endtask

	// input driver: predict on transfer, then offer the next pending item
	always @(posedge clk or negedge arst_n) begin : drive_proc
		bucket_op_t accepted_op;
		bucket_op_t next_op;
		logic take;
		if (!arst_n) begin
			in_valid    <= 1'b0;
			kind        <= OP_INSERT;
			key         <= '0;
			entry_value <= '0;
		end else begin
			take = in_valid && in_ready;
			if (take) begin
				accepted_op.kind = kind;
				accepted_op.key  = key;
				accepted_op.data = entry_value;
				expected_results.push_back(bucket_apply(accepted_op));
				ops_by_kind[kind]++;
			end
			if (!in_valid || take) begin
				if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_op = pending_ops.pop_front();
					in_valid    <= 1'b1;
					kind        <= next_op.kind;
					key         <= next_op.key;
					entry_value <= next_op.data;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor: check each result transfer, then pick the next ready
	always @(posedge clk or negedge arst_n) begin : monitor_proc
		bucket_result_t want;
		if (!arst_n) begin
			out_ready  <= 1'b0;
			hold_left  <= 0;
			hold_taken <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with no operation outstanding");
				end else begin
					want = expected_results.pop_front();
					if (success !== want.success)
						report_mismatch($sformatf("success got %b expected %b",
							success, want.success));
					if (found_value !== want.found)
						report_mismatch($sformatf("found_value got %h expected %h",
							found_value, want.found));
					if (occupancy !== want.occ)
						report_mismatch($sformatf("occupancy got %0d expected %0d",
							occupancy, want.occ));
					if (is_full !== want.full)
						report_mismatch($sformatf("is_full got %b expected %b",
							is_full, want.full));
					if (is_empty !== want.empty)
						report_mismatch($sformatf("is_empty got %b expected %b",
							is_empty, want.empty));
					success_count += want.success;
					full_seen     += want.full;
					empty_seen    += want.empty;
				end
				results_checked++;
			end
			// long receiver hold-off once armed, random stalls otherwise
			if (hold_arm && !hold_taken) begin
				hold_taken <= 1'b1;
				hold_left  <= LONG_HOLD;
				out_ready  <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// watchdog on cycles with no transfer on either channel
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired after %0d cycles without a transfer", stall_cycles);
			$display("TB_ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			shadow_valid[i] = 1'b0;
			shadow_key[i]   = '0;
			shadow_value[i] = '0;
		end
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7fff_ffff;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hffff_ffff;
		for (int i = 4; i < POOL_SIZE; i++) begin
			key_pool[i] = $urandom;
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// slow receiver
		send_idle_pct = 28;
		recv_idle_pct = 82;

		// misses on an empty bucket
		push_op(OP_LOOKUP, 32'h0000_0000, 32'h1234_5678);
		push_op(OP_REMOVE, 32'hffff_ffff, 32'h0);
		push_op(OP_UPDATE, 32'h7fff_ffff, 32'hffff_ffff);
		// fill every slot, last key a duplicate of the first
		push_op(OP_INSERT, 32'h8000_0000, 32'h0000_0000);
		push_op(OP_INSERT, 32'h7fff_ffff, 32'hffff_ffff);
		push_op(OP_INSERT, 32'h0000_0000, 32'h8000_0001);
		push_op(OP_INSERT, 32'hffff_ffff, 32'h7fff_fffe);
		push_op(OP_INSERT, 32'h5555_5555, 32'haaaa_aaaa);
		push_op(OP_INSERT, 32'haaaa_aaaa, 32'h5555_5555);
		push_op(OP_INSERT, 32'h1234_5678, 32'hdead_beef);
		push_op(OP_INSERT, 32'h8000_0000, 32'ha5a5_a5a5);
		// insert into a full bucket
		push_op(OP_INSERT, 32'h0000_0001, 32'h1111_1111);
		// duplicates resolve to the lowest slot
		push_op(OP_LOOKUP, 32'h8000_0000, 32'h0);
		push_op(OP_UPDATE, 32'h8000_0000, 32'hffff_ffff);
		push_op(OP_LOOKUP, 32'h8000_0000, 32'h0);
		push_op(OP_REMOVE, 32'h8000_0000, 32'h0);
		push_op(OP_LOOKUP, 32'h8000_0000, 32'h0);
		// reuse of the freed low slot by a duplicate key
		push_op(OP_INSERT, 32'h7fff_ffff, 32'h0f0f_0f0f);
		push_op(OP_LOOKUP, 32'h7fff_ffff, 32'h0);
		push_op(OP_REMOVE, 32'hffff_ffff, 32'h0);
		push_op(OP_LOOKUP, 32'hffff_ffff, 32'h0);
		push_op(OP_UPDATE, 32'h0000_0000, 32'h5a5a_5a5a);
		push_op(OP_LOOKUP, 32'h0000_0000, 32'h0);
		wait_drained();

		queue_random_ops(160);
		wait_drained();

		// slow sender
		send_idle_pct = 82;
		recv_idle_pct = 28;
		queue_random_ops(160);
		wait_drained();

		// no idling, with one long receiver hold-off while items queue up
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random_ops(160);
		hold_arm = 1'b1;
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("ran %0d operations: %0d insert, %0d lookup, %0d remove, %0d update; %0d succeeded",
			ops_by_kind[OP_INSERT] + ops_by_kind[OP_LOOKUP] + ops_by_kind[OP_REMOVE] +
			ops_by_kind[OP_UPDATE], ops_by_kind[OP_INSERT], ops_by_kind[OP_LOOKUP],
			ops_by_kind[OP_REMOVE], ops_by_kind[OP_UPDATE], success_count);
		$display("checked %0d results; bucket reported full %0d times, empty %0d times",
			results_checked, full_seen, empty_seen);
		if (err_count == 0 && expected_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches, %0d results outstanding", err_count,
				expected_results.size());
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/bst_pkg.sv
hdl/bst_slot_store.sv
hdl/bucket_slot_table.sv
verif/bucket_slot_table_test.sv
